>>> rtl/bba_pkg.sv
// types and constants shared by the buddy block allocator
`default_nettype none
package bba_pkg;

    localparam int unsigned HDR_BYTES = 16;
    localparam int unsigned MIN_LOG2 = 4;
    localparam logic [4:0] POOL_LOG2_LO = 5'd12;
    localparam logic [4:0] POOL_LOG2_HI = 5'd16;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [15:0] request_bytes;
        logic [15:0] free_address;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] block_address;
        logic [16:0] block_bytes;
    } out_t;

    // one table entry per 16-byte granule, order stored minus four
    typedef struct packed {
        logic       start;
        logic       free;
        logic [3:0] ord;
    } entry_t;

endpackage
`default_nettype wire

>>> rtl/buddy_block_allocator_core.sv
// buddy block allocator: granule table memory and request sequencer
//
// Usage: cfg_valid/cfg_ready/cfg_data writes pool_size_log2 (clamped to
// 12..16 and to the built pool) and restarts the pool as one free block.
// in_valid/in_ready/in_data takes one allocate or free request; exactly one
// result beat per request leaves on out_valid/out_ready/out_data.
// One request is worked at a time, in_ready is high only when idle.
// The granule table is one memory with a registered read.
// Allocate: walks the blocks from address zero (up to pool/16 blocks),
// then splits the found block level by level and loads the result
// register; a request whose size exceeds the pool answers without the
// walk.
// Free: checks the block, then reads, checks and merges each buddy in
// turn until a check finds that merging ends.
// The result is held in an output register; while the receiver stalls
// the sequencer waits with the finished result and takes no new request.
// After reset and after every configuration write a clearing pass runs
// through the table, one entry per granule (POOL_BYTES/16, 4096 by default), during which
// no request is taken.
`default_nettype none
module buddy_block_allocator_core #(
    parameter int unsigned POOL_BYTES = 65536
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [4:0]     cfg_data,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire bba_pkg::in_t   in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output bba_pkg::out_t       out_data
);
    import bba_pkg::*;

    localparam int unsigned GW = $clog2(POOL_BYTES / 16);
    localparam int unsigned DEPTH = 1 << GW;
    localparam int unsigned AW = (GW + 5 > 17) ? GW + 5 : 17;
    localparam logic [4:0] MAX_LOG2 = 5'($clog2(POOL_BYTES));
    localparam logic [4:0] RST_LOG2 = (MAX_LOG2 < POOL_LOG2_HI) ? MAX_LOG2 : POOL_LOG2_HI;
    localparam logic [AW-1:0] ONE = AW'(1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_A_CHK, S_SPLIT, S_F_CHK, S_M_RD, S_M_CHK, S_M_WLO, S_DONE
    } state_t;

    state_t          state_reg;
    logic [GW-1:0]   clr_reg;
    logic [4:0]      log2_reg;
    logic [AW-1:0]   a_reg, found_reg, s_reg;
    logic [4:0]      k_reg, o_reg, fo_reg;
    logic [1:0]      nfree_reg;
    logic            have_reg;
    out_t            res_reg;
    logic            out_valid_reg;
    out_t            out_data_reg;

    entry_t          mem [DEPTH];
    entry_t          rdata;
    logic            we;
    logic [GW-1:0]   waddr, raddr;
    entry_t          wdata;

    function automatic logic [GW-1:0] gi(input logic [AW-1:0] addr);
        gi = addr[GW+3:4];
    endfunction

    // clamp of the written pool order
    logic [4:0] cfg_eff;
    always_comb
    begin
        cfg_eff = cfg_data;
        if (cfg_eff < POOL_LOG2_LO) cfg_eff = POOL_LOG2_LO;
        if (cfg_eff > POOL_LOG2_HI) cfg_eff = POOL_LOG2_HI;
        if (cfg_eff > MAX_LOG2) cfg_eff = MAX_LOG2;
    end

    // rounded request order: bit length of total minus one
    logic [16:0] total_m1;
    logic [4:0]  k_in;
    always_comb
    begin
        total_m1 = 17'(in_data.request_bytes) + 17'(HDR_BYTES - 1);
        k_in = 5'd0;
        for (int i = 0; i < 17; i++)
        begin
            if (total_m1[i]) k_in = 5'(i + 1);
        end
    end

    logic [AW-1:0] pool_p;
    logic [AW-1:0] fa_ext, hdr_a;
    logic [4:0]    rd_ord;
    logic [AW-1:0] a_step;
    logic [AW-1:0] bud_bit, bud;
    logic [4:0]    o_dec;
    always_comb
    begin
        pool_p = ONE << log2_reg;
        fa_ext = AW'(in_data.free_address);
        hdr_a = fa_ext - AW'(HDR_BYTES);
        rd_ord = 5'(rdata.ord) + 5'(MIN_LOG2);
        a_step = a_reg + (ONE << rd_ord);
        bud_bit = ONE << o_reg;
        bud = s_reg ^ bud_bit;
        o_dec = o_reg - 5'd1;
    end

    // table memory port control
    always_comb
    begin
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = gi(a_reg);
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg;
                if (clr_reg == '0)
                begin
                    wdata.start = 1'b1;
                    wdata.free = 1'b1;
                    wdata.ord = 4'(log2_reg - 5'(MIN_LOG2));
                end
            end
            S_IDLE:
            begin
                raddr = (in_data.cmd == CMD_FREE) ? gi(hdr_a) : '0;
            end
            S_A_CHK:
            begin
                raddr = gi(a_step);
            end
            S_SPLIT:
            begin
                we = 1'b1;
                if (o_reg > k_reg)
                begin
                    waddr = gi(found_reg + (ONE << o_dec));
                    wdata.start = 1'b1;
                    wdata.free = 1'b1;
                    wdata.ord = 4'(o_dec - 5'(MIN_LOG2));
                end
                else
                begin
                    waddr = gi(found_reg);
                    wdata.start = 1'b1;
                    wdata.free = 1'b0;
                    wdata.ord = 4'(k_reg - 5'(MIN_LOG2));
                end
            end
            S_F_CHK:
            begin
                we = rdata.start && !rdata.free;
                waddr = gi(s_reg);
                wdata = rdata;
                wdata.free = 1'b1;
            end
            S_M_RD:
            begin
                raddr = gi(bud);
            end
            S_M_CHK:
            begin
                we = rdata.start && rdata.free && (rd_ord == o_reg);
                waddr = gi(s_reg | bud_bit);
            end
            S_M_WLO:
            begin
                we = 1'b1;
                waddr = gi(s_reg & ~bud_bit);
                wdata.start = 1'b1;
                wdata.free = 1'b1;
                wdata.ord = 4'(o_reg + 5'd1 - 5'(MIN_LOG2));
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // granule table with registered read
    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            log2_reg <= RST_LOG2;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == GW'(DEPTH - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (in_data.cmd == CMD_ALLOC)
                        begin
                            k_reg <= (k_in < 5'(MIN_LOG2)) ? 5'(MIN_LOG2) : k_in;
                            a_reg <= '0;
                            nfree_reg <= 2'd0;
                            have_reg <= 1'b0;
                            if (k_in > log2_reg)
                            begin
                                res_reg <= '{ST_NO_SPACE, 16'd0, 17'd0};
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_A_CHK;
                            end
                        end
                        else if (fa_ext < AW'(HDR_BYTES) || fa_ext[3:0] != 4'd0
                                 || hdr_a >= pool_p)
                        begin
                            res_reg <= '{ST_BAD_FREE, 16'd0, 17'd0};
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            s_reg <= hdr_a;
                            res_reg.block_address <= in_data.free_address;
                            state_reg <= S_F_CHK;
                        end
                    end
                end
                S_A_CHK:
                begin
                    a_reg <= a_step;
                    if (rdata.free)
                    begin
                        if (nfree_reg != 2'd2) nfree_reg <= nfree_reg + 2'd1;
                        if (!have_reg && rd_ord >= k_reg)
                        begin
                            have_reg <= 1'b1;
                            found_reg <= a_reg;
                            fo_reg <= rd_ord;
                        end
                    end
                    if (a_step >= pool_p) state_reg <= S_SPLIT;
                    // decision uses the values including this block
                    if (a_step >= pool_p)
                    begin
                        if (!(have_reg || (rdata.free && rd_ord >= k_reg))
                            || ((nfree_reg + 2'(rdata.free)) == 2'd1 &&
                                (have_reg ? fo_reg : rd_ord) == k_reg))
                        begin
                            res_reg <= '{ST_NO_SPACE, 16'd0, 17'd0};
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            o_reg <= have_reg ? fo_reg : rd_ord;
                            if (!have_reg) found_reg <= a_reg;
                        end
                    end
                end
                S_SPLIT:
                begin
                    if (o_reg > k_reg)
                    begin
                        o_reg <= o_dec;
                    end
                    else
                    begin
                        res_reg.status <= ST_OK;
                        res_reg.block_address <= 16'(found_reg + AW'(HDR_BYTES));
                        res_reg.block_bytes <= 17'(ONE << k_reg);
                        state_reg <= S_DONE;
                    end
                end
                S_F_CHK:
                begin
                    if (!rdata.start || rdata.free)
                    begin
                        res_reg <= '{ST_BAD_FREE, 16'd0, 17'd0};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        res_reg.status <= ST_OK;
                        res_reg.block_bytes <= 17'(ONE << rd_ord);
                        o_reg <= rd_ord;
                        state_reg <= S_M_RD;
                    end
                end
                S_M_RD:
                begin
                    if (o_reg >= log2_reg || bud >= pool_p) state_reg <= S_DONE;
                    else state_reg <= S_M_CHK;
                end
                S_M_CHK:
                begin
                    if (rdata.start && rdata.free && (rd_ord == o_reg)) state_reg <= S_M_WLO;
                    else state_reg <= S_DONE;
                end
                S_M_WLO:
                begin
                    s_reg <= s_reg & ~bud_bit;
                    o_reg <= o_reg + 5'd1;
                    state_reg <= S_M_RD;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                end
            endcase
            // configuration beat restarts the pool
            if (cfg_valid)
            begin
                log2_reg <= cfg_eff;
                clr_reg <= '0;
                state_reg <= S_CLEAR;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// self-checking testbench for the buddy block allocator core
`default_nettype none
module tb_top;
    import bba_pkg::*;

    typedef struct {
        in_t req;
        bit  pick_live;
    } pending_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [4:0] cfg_data;
    logic in_valid;
    logic in_ready;
    in_t in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    pending_t pending_reqs[$];
    out_t expected_results[$];
    int unsigned live_blocks[$];

    // allocator shadow state
    bit tbl_start[4096];
    bit tbl_free[4096];
    int unsigned tbl_order[4096];
    int unsigned pool_log2;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit in_taken;
    int n_err;

    buddy_block_allocator_core i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    // clock and reset
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned gran(int unsigned a);
        return (a / 16) % 4096;
    endfunction

    // rebuild the pool as one free block
    function automatic void pool_restart(logic [4:0] v);
        int unsigned l;
        l = v;
        if (l < 12) l = 12;
        if (l > 16) l = 16;
        pool_log2 = l;
        for (int i = 0; i < 4096; i++)
        begin
            tbl_start[i] = 0;
            tbl_free[i] = 0;
            tbl_order[i] = 0;
        end
        tbl_start[0] = 1;
        tbl_free[0] = 1;
        tbl_order[0] = l;
        live_blocks.delete();
    endfunction

    // expected result of one request, state updated
    function automatic out_t predict_request(in_t r);
        out_t o;
        int unsigned p, need, k, a, found, nfree, total, g, ord, h, s, b, bg, lo, hi;
        bit have;
        p = 1 << pool_log2;
        o = '0;
        if (r.cmd == CMD_ALLOC)
        begin
            need = 16;
            k = 4;
            a = 0;
            nfree = 0;
            found = 0;
            have = 0;
            total = r.request_bytes + HDR_BYTES;
            while (need < total)
            begin
                need = need << 1;
                k++;
            end
            if (need <= p)
            begin
                while (a < p)
                begin
                    g = gran(a);
                    if (tbl_free[g])
                    begin
                        nfree++;
                        if (!have && (1 << tbl_order[g]) >= need)
                        begin
                            have = 1;
                            found = a;
                        end
                    end
                    a += 1 << tbl_order[g];
                end
            end
            if (!have || (nfree == 1 && (1 << tbl_order[gran(found)]) == need))
            begin
                o.status = ST_NO_SPACE;
                return o;
            end
            g = gran(found);
            ord = tbl_order[g];
            while (ord > k)
            begin
                ord--;
                h = gran(found + (1 << ord));
                tbl_start[h] = 1;
                tbl_free[h] = 1;
                tbl_order[h] = ord;
            end
            tbl_order[g] = k;
            tbl_free[g] = 0;
            o.status = ST_OK;
            o.block_address = 16'(found + HDR_BYTES);
            o.block_bytes = 17'(need);
            live_blocks.push_back(found + HDR_BYTES);
            return o;
        end
        // free path
        if (r.free_address < HDR_BYTES)
        begin
            o.status = ST_BAD_FREE;
            return o;
        end
        h = r.free_address - HDR_BYTES;
        g = gran(h);
        if ((h % 16) != 0 || h >= p || !tbl_start[g] || tbl_free[g])
        begin
            o.status = ST_BAD_FREE;
            return o;
        end
        ord = tbl_order[g];
        o.status = ST_OK;
        o.block_address = r.free_address;
        o.block_bytes = 17'(1 << ord);
        tbl_free[g] = 1;
        s = h;
        while (ord < pool_log2)
        begin
            b = s ^ (1 << ord);
            if (b >= p) break;
            bg = gran(b);
            if (!tbl_start[bg] || !tbl_free[bg] || tbl_order[bg] != ord) break;
            lo = (s < b) ? s : b;
            hi = (s < b) ? b : s;
            tbl_start[gran(hi)] = 0;
            tbl_free[gran(hi)] = 0;
            tbl_order[gran(hi)] = 0;
            ord++;
            tbl_order[gran(lo)] = ord;
            tbl_free[gran(lo)] = 1;
            s = lo;
        end
        for (int i = 0; i < live_blocks.size(); i++)
        begin
            if (live_blocks[i] == r.free_address)
            begin
                live_blocks.delete(i);
                break;
            end
        end
        return o;
    endfunction

    task automatic push_req(logic c, int unsigned rb, int unsigned fa, bit live);
        pending_t e;
        e.req.cmd = c;
        e.req.request_bytes = 16'(rb);
        e.req.free_address = 16'(fa);
        e.pick_live = live;
        pending_reqs.push_back(e);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_pool_log2(logic [4:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        pool_restart(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random request mix, mostly well-formed alloc/free traffic
    task automatic push_random(int n);
        int unsigned r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    push_req(CMD_ALLOC, $urandom_range(0, 200), $urandom, 0);
                else if (r < 95)
                    push_req(CMD_ALLOC, $urandom_range(0, 2100), $urandom, 0);
                else
                    push_req(CMD_ALLOC, $urandom, $urandom, 0);
            end
            else if (r < 93)
                push_req(CMD_FREE, $urandom, 0, 1);
            else if (r < 97)
                push_req(CMD_FREE, $urandom, $urandom_range(1, 1024) * 16, 0);
            else
                push_req(CMD_FREE, $urandom, $urandom, 0);
        end
    endtask

    // stimulus sequencing
    initial
    begin
        logic [4:0] cfg_vals[6];
        int counts[6];
        cfg_vals = '{5'd0, 5'd13, 5'd31, 5'd14, 5'd12, 5'd15};
        counts = '{200, 200, 150, 250, 200, 150};
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pool_restart(5'd16);
        @(posedge rst_n);

        // directed on the reset pool
        push_req(CMD_ALLOC, 16'hFFFF, 16'hFFFF, 0);
        push_req(CMD_ALLOC, 0, 0, 0);
        push_req(CMD_ALLOC, 65520, 0, 0);
        push_req(CMD_FREE, 16'hFFFF, 0, 0);
        push_req(CMD_FREE, 0, 15, 0);
        push_req(CMD_FREE, 0, 17, 0);
        push_req(CMD_FREE, 0, 48, 0);
        push_req(CMD_FREE, 0, 16, 0);
        push_req(CMD_FREE, 0, 16, 0);
        push_req(CMD_FREE, 0, 16'hFFF0, 0);
        wait_drained();

        // directed on the smallest pool
        write_pool_log2(5'd12);
        push_req(CMD_ALLOC, 4080, 0, 0);
        push_req(CMD_ALLOC, 2032, 0, 0);
        push_req(CMD_ALLOC, 2032, 0, 0);
        push_req(CMD_ALLOC, 2033, 0, 0);
        push_req(CMD_FREE, 0, 4112, 0);
        push_req(CMD_ALLOC, 0, 0, 0);
        push_req(CMD_ALLOC, 0, 0, 0);
        push_req(CMD_FREE, 0, 16, 0);
        push_req(CMD_FREE, 0, 32, 0);
        push_req(CMD_FREE, 0, 16, 0);
        push_req(CMD_ALLOC, 1000, 16'h5555, 0);
        push_req(CMD_FREE, 16'hAAAA, 0, 1);
        wait_drained();

        // random phases, each with a pool write and an idling mix
        for (int ph = 0; ph < 6; ph++)
        begin
            write_pool_log2(cfg_vals[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 87; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 87; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            push_random(counts[ph] / 2);
            // sender holds off until every result is back
            wait_drained();
            push_random(counts[ph] - counts[ph] / 2);
            wait_drained();
        end

        repeat (50) @(posedge clk);
        if (n_err == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // request driver
    always @(negedge clk)
    begin
        pending_t e;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else if (in_valid && !in_taken)
        begin
            in_valid <= 1'b1;
        end
        else if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            e = pending_reqs.pop_front();
            if (e.pick_live)
            begin
                if (live_blocks.size() != 0)
                    e.req.free_address = 16'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
                else
                    e.req.free_address = $urandom;
            end
            in_data <= e.req;
            in_valid <= 1'b1;
        end
        else
        begin
            in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial
    begin
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        in_taken = 1'b0;
        n_err = 0;
    end

    // input acceptance and prediction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expected_results.push_back(predict_request(in_data));
            in_taken <= 1'b1;
        end
        else
        begin
            in_taken <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        out_t exp_beat;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result beat %h", out_data);
            end
            else
            begin
                exp_beat = expected_results.pop_front();
                if (exp_beat.status !== out_data.status
                    || exp_beat.block_address !== out_data.block_address
                    || exp_beat.block_bytes !== out_data.block_bytes)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp st %0d addr %h bytes %0d, %s %0d %s %h %s %0d",
                            exp_beat.status, exp_beat.block_address, exp_beat.block_bytes,
                            "got st", out_data.status, "addr", out_data.block_address,
                            "bytes", out_data.block_bytes);
                end
            end
        end
    end

    // run limit
    initial
    begin
        #400000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

>>> buddy_block_allocator_core.f
rtl/bba_pkg.sv
rtl/buddy_block_allocator_core.sv
dv/tb_top.sv
